@@ design/bfsp_pkg.sv @@
// Shared types, constants and a saturating add for the shortest-path block.
package bfsp_pkg;
   localparam logic [0:0] CSR_VERTEX_COUNT  = 1'b0;
   localparam logic [0:0] CSR_SOURCE_VERTEX = 1'b1;
   localparam int unsigned MAX_VERTICES = 16;
   localparam int unsigned COUNT_BITS  = 5;
   localparam int unsigned VERTEX_BITS = 4;
   localparam int unsigned COST_BITS   = 32;
   localparam logic signed [31:0] COST_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] COST_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic        valid;
      logic [3:0]  vertex_index;
      logic [31:0] path_cost;
      logic [3:0]  parent_vertex;
      logic        has_parent;
      logic        reached;
      logic        negative_cycle;
      logic        last;
   } rsp_type;

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] s;
      s = {a[31], a} + {b[31], b};
      if (s > 33'sd2147483647) return COST_MAX;
      if (s < -33'sd2147483648) return COST_MIN;
      return s[31:0];
   endfunction
endpackage

@@ design/bfsp_weight_mem.sv @@
// Adjacency weight memory with a registered read port.
module bfsp_weight_mem #(
   parameter int unsigned ADDR_BITS = 8,
   parameter int unsigned DATA_BITS = 16
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);
   logic [DATA_BITS-1:0] mem [(1 << ADDR_BITS)];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

@@ design/bellman_ford_shortest_paths.sv @@
// Top level: weight load, relaxation sequencer and result output.
// Loads n*n weights, one word per cycle while busy is low. The word that completes
// the matrix raises busy: a setup state, then n-1 relaxation passes and one check
// pass, each reading one edge per cycle through the weight memory and ending in a
// drain step, then a restart before the next pass; every distance update replays
// the edge read behind it. Then one result per vertex, or a single cycle report,
// follows, each result strobed in the cycle after its output state; busy drops as
// the last result appears. Results cannot be stalled.
module bellman_ford_shortest_paths #(
   parameter int unsigned WEIGHT_BITS  = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic signed [WEIGHT_BITS-1:0] req_edge_weight,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [0:0]              csr_index,
   input  logic [bfsp_pkg::COUNT_BITS-1:0] csr_data,
   output logic                    rsp_strobe,
   output logic [3:0]              rsp_vertex_index,
   output logic signed [31:0]      rsp_path_cost,
   output logic [3:0]              rsp_parent_vertex,
   output logic                    rsp_has_parent,
   output logic                    rsp_reached,
   output logic                    rsp_negative_cycle,
   output logic                    rsp_last
);
   localparam int unsigned MAX_VERTICES = bfsp_pkg::MAX_VERTICES;
   localparam int unsigned VB = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int unsigned AB = 2 * VB;
   localparam int unsigned CB = $clog2(MAX_VERTICES * MAX_VERTICES + 1);
   localparam int unsigned NB = $clog2(MAX_VERTICES + 1);

   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_INIT  = 3'd1;
   localparam logic [2:0] ST_RELAX = 3'd2;
   localparam logic [2:0] ST_OUT   = 3'd3;
   localparam logic [2:0] ST_NEG   = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [4:0]    vcount_ff;
   logic [3:0]    source_ff;
   logic [CB-1:0] load_ff;
   logic [VB-1:0] u_ff, u_in, v_ff, v_in, u_d_ff, v_d_ff;
   logic [NB-1:0] pass_ff, pass_in;
   logic          run_ff, run_in, run_d_ff, run_d_in;
   logic [MAX_VERTICES-1:0] reached_ff, reached_in, haspar_ff, haspar_in;
   logic signed [31:0] dist_mem [MAX_VERTICES];
   logic [VB-1:0]      par_mem  [MAX_VERTICES];
   logic signed [31:0] du_ff, dv_ff;
   logic [WEIGHT_BITS-1:0] w_rd;
   bfsp_pkg::rsp_type rsp_ff;

   logic [NB-1:0] n;
   always_comb begin
      if (vcount_ff == 5'd0) n = NB'(1);
      else if (32'(vcount_ff) > MAX_VERTICES) n = NB'(MAX_VERTICES);
      else n = NB'(vcount_ff);
   end
   logic [CB-1:0] nn;
   assign nn = CB'(32'(n) * 32'(n));
   logic [VB-1:0] nm1;
   assign nm1 = VB'(n - NB'(1));

   logic accept;
   assign busy   = (state_ff != ST_LOAD);
   assign accept = start && !busy;
   assign csr_ready = 1'b1;

   logic [AB-1:0] rd_addr;
   assign rd_addr = AB'(32'(u_ff) * 32'(n) + 32'(v_ff));

   bfsp_weight_mem #(.ADDR_BITS(AB), .DATA_BITS(WEIGHT_BITS)) u_wmem (
      .clock   (clock),
      .wr_en   (accept && (32'(load_ff) < MAX_VERTICES * MAX_VERTICES)),
      .wr_addr (load_ff[AB-1:0]),
      .wr_data (req_edge_weight),
      .rd_addr (rd_addr),
      .rd_data (w_rd)
   );

   // relax evaluation on the delayed edge
   logic signed [31:0] w_ext, cand;
   logic               relax;
   assign w_ext = 32'(signed'(w_rd));
   assign cand  = bfsp_pkg::sat_add(du_ff, w_ext);
   assign relax = run_d_ff && reached_ff[u_d_ff] && (w_rd != '0) &&
                  (!reached_ff[v_d_ff] || cand < dv_ff);
   logic checking;
   assign checking = (32'(pass_ff) == 32'(n) - 1);

   logic last_edge;
   assign last_edge = (u_ff == nm1) && (v_ff == nm1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD:  if (accept && (load_ff + CB'(1) >= nn)) state_in = ST_INIT;
         ST_INIT:  state_in = ST_RELAX;
         ST_RELAX: if (relax && checking) state_in = ST_NEG;
                   else if (!run_ff && !run_d_ff && checking) state_in = ST_OUT;
         ST_OUT:   if (v_ff == nm1) state_in = ST_LOAD;
         ST_NEG:   state_in = ST_LOAD;
         default:  state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      u_in       = u_ff;
      v_in       = v_ff;
      pass_in    = pass_ff;
      run_in     = run_ff;
      run_d_in   = run_ff;
      reached_in = reached_ff;
      haspar_in  = haspar_ff;
      case (state_ff)
         ST_INIT: begin
            reached_in = '0;
            haspar_in  = '0;
            if (32'(source_ff) < 32'(n)) reached_in[source_ff[VB-1:0]] = 1'b1;
            u_in = '0; v_in = '0; pass_in = '0; run_in = 1'b1;
         end
         ST_RELAX: begin
            if (run_ff) begin
               if (v_ff == nm1) begin v_in = '0; u_in = u_ff + VB'(1); end
               else v_in = v_ff + VB'(1);
               if (last_edge) run_in = 1'b0;
            end
            // one-edge interlock: a relax clears the pipeline and replays
            if (relax && !checking) begin
               reached_in[v_d_ff] = 1'b1;
               haspar_in[v_d_ff]  = 1'b1;
               if (run_ff || !(u_d_ff == nm1 && v_d_ff == nm1)) begin
                  run_in   = 1'b1;
                  run_d_in = 1'b0;
                  if (v_d_ff == nm1) begin v_in = '0; u_in = u_d_ff + VB'(1); end
                  else begin v_in = v_d_ff + VB'(1); u_in = u_d_ff; end
               end
            end
            if (!run_ff && !run_d_ff) begin
               if (!checking) begin
                  pass_in = pass_ff + NB'(1);
                  run_in = 1'b1; u_in = '0; v_in = '0;
               end else v_in = '0;
            end
         end
         ST_OUT: v_in = v_ff + VB'(1);
         ST_NEG: begin
            run_in   = 1'b0;
            run_d_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         vcount_ff <= 5'd16;
         source_ff <= 4'd0;
         load_ff   <= '0;
         run_ff    <= 1'b0;
         run_d_ff  <= 1'b0;
         reached_ff <= '0;
         haspar_ff <= '0;
         rsp_ff.valid <= 1'b0;
      end else begin
         state_ff   <= state_in;
         run_ff     <= run_in;
         run_d_ff   <= run_d_in;
         reached_ff <= reached_in;
         haspar_ff  <= haspar_in;
         u_ff       <= u_in;
         v_ff       <= v_in;
         pass_ff    <= pass_in;
         rsp_ff.valid <= (state_ff == ST_OUT) || (state_ff == ST_NEG);
         if (csr_valid && csr_ready) begin
            if (csr_index == bfsp_pkg::CSR_VERTEX_COUNT) vcount_ff <= csr_data;
            else source_ff <= csr_data[3:0];
         end
         u_d_ff   <= u_ff;
         v_d_ff   <= v_ff;
         du_ff    <= dist_mem[u_ff];
         dv_ff    <= dist_mem[v_ff];
         case (state_ff)
            ST_LOAD: if (accept) load_ff <= (load_ff + CB'(1) >= nn) ? '0 : load_ff + CB'(1);
            ST_INIT: if (32'(source_ff) < 32'(n)) dist_mem[source_ff[VB-1:0]] <= '0;
            ST_RELAX: begin
               if (relax && !checking) begin
                  dist_mem[v_d_ff] <= cand;
                  par_mem[v_d_ff]  <= u_d_ff;
               end
            end
            ST_OUT: begin
               rsp_ff.vertex_index   <= 4'(v_ff);
               rsp_ff.path_cost      <= reached_ff[v_ff] ? dist_mem[v_ff] : '0;
               rsp_ff.parent_vertex  <= (reached_ff[v_ff] && haspar_ff[v_ff])
                                        ? 4'(par_mem[v_ff]) : 4'd0;
               rsp_ff.has_parent     <= reached_ff[v_ff] && haspar_ff[v_ff];
               rsp_ff.reached        <= reached_ff[v_ff];
               rsp_ff.negative_cycle <= 1'b0;
               rsp_ff.last           <= (v_ff == nm1);
            end
            ST_NEG: begin
               rsp_ff.vertex_index   <= 4'd0;
               rsp_ff.path_cost      <= '0;
               rsp_ff.parent_vertex  <= 4'd0;
               rsp_ff.has_parent     <= 1'b0;
               rsp_ff.reached        <= 1'b0;
               rsp_ff.negative_cycle <= 1'b1;
               rsp_ff.last           <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign rsp_strobe         = rsp_ff.valid;
   assign rsp_vertex_index   = rsp_ff.vertex_index;
   assign rsp_path_cost      = rsp_ff.path_cost;
   assign rsp_parent_vertex  = rsp_ff.parent_vertex;
   assign rsp_has_parent     = rsp_ff.has_parent;
   assign rsp_reached        = rsp_ff.reached;
   assign rsp_negative_cycle = rsp_ff.negative_cycle;
   assign rsp_last           = rsp_ff.last;

   a_no_rsp_while_loading: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD && $past(state_ff) == ST_LOAD |-> !rsp_ff.valid)
      else $error("result while loading");
   a_neg_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.valid && rsp_ff.negative_cycle |-> rsp_ff.last)
      else $error("cycle report not last");
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.valid && rsp_ff.last |-> state_ff == ST_LOAD)
      else $error("run did not end");
endmodule
